FILE: hdl/slpg_pkg.sv
package slpg_pkg;

  // lamp counts
  localparam int MAX_LAMPS = 8;
  localparam int LAMP_W    = $clog2(MAX_LAMPS);
  localparam int CNT_W     = $clog2(MAX_LAMPS + 1);

  // field widths
  localparam int TIME_W     = 48;
  localparam int IDLE_W     = 22;
  localparam int PCT_W      = 7;
  localparam int CMD_W      = 2;
  localparam int MODE_W     = 3;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // stream word widths
  localparam int S_DATA_W = 64;
  localparam int S_USER_W = CMD_W;
  localparam int M_DATA_W = 40;

  // upload progress: lit = count * pct / 100 by reciprocal
  localparam int PCT_MAX    = 100;
  localparam int PROD_W     = $clog2(MAX_LAMPS * PCT_MAX + 1);
  localparam int LIT_SHIFT  = 16;
  localparam int LIT_RCP_W  = 10;
  localparam logic [LIT_RCP_W-1:0] LIT_RCP = 10'd656;

  // breath phase: period 2000000 us = 2^7 * 15625
  localparam int LSB_W   = 7;
  localparam int X_W     = TIME_W - LSB_W;
  localparam int RES_W   = 14;
  localparam int P_W     = 27;
  localparam int PB_W    = 24;
  localparam int Q_W     = 14;
  localparam int DQ_W    = 28;
  localparam int V_W     = 22;
  localparam logic [RES_W-1:0] ODD_DIV = 14'd15625;
  // 2^14 mod 15625 and 2^28 mod 15625
  localparam logic [9:0]       R14     = 10'd759;
  localparam logic [RES_W-1:0] R28     = 14'd13581;
  localparam int Q_SHIFT = 41;
  localparam int Q_RCP_W = 28;
  localparam logic [Q_RCP_W-1:0] Q_RCP = 28'd140737489;
  localparam int I_SHIFT = 36;
  localparam int I_RCP_W = 23;
  localparam logic [I_RCP_W-1:0] I_RCP = 23'd4398047;

  // lamp colours
  localparam logic [CHAN_W-1:0] BOOT_G  = 8'd40;
  localparam logic [CHAN_W-1:0] BOOT_B  = 8'd160;
  localparam logic [CHAN_W-1:0] SAFE_R  = 8'd200;
  localparam logic [CHAN_W-1:0] WAIT_R  = 8'd170;
  localparam logic [CHAN_W-1:0] WAIT_G  = 8'd90;
  localparam logic [CHAN_W-1:0] RUN_G   = 8'd150;
  localparam logic [CHAN_W-1:0] RUN_B   = 8'd30;
  localparam logic [CHAN_W-1:0] UP_G    = 8'd40;
  localparam logic [CHAN_W-1:0] UP_B    = 8'd160;
  localparam logic [CHAN_W-1:0] DIM_G   = 8'd3;
  localparam logic [CHAN_W-1:0] DIM_B   = 8'd12;
  localparam logic [CHAN_W-1:0] FULL_BR = 8'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_MODE  = 2'd1,
    CMD_TELEM = 2'd2
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF  = 3'd0,
    MODE_BOOT = 3'd1,
    MODE_SAFE = 3'd2,
    MODE_WAIT = 3'd3,
    MODE_RUN  = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAMP_COUNT  = 2'd0,
    REG_START_TIME  = 2'd1,
    REG_IDLE_WINDOW = 2'd2,
    REG_DIM_LEVEL   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]        lamp_count;
    logic [TIME_W-1:0] start_time;
    logic [IDLE_W-1:0] idle_window;
    logic [CHAN_W-1:0] dim_level;
  } cfg_t;

  // per tick information carried along the phase pipeline
  typedef struct packed {
    mode_e             show;
    logic              up;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  lit;
    logic [CHAN_W-1:0] dim;
    logic [LSB_W-1:0]  lsb;
  } meta_t;

  typedef struct packed {
    meta_t             meta;
    logic [PROD_W-1:0] prod;
    logic [X_W-1:0]    x;
  } tick_t;

  typedef struct packed {
    logic              up;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  lit;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] bright;
    logic              gam;
  } frame_t;

  // quarter wave of 96*cos, 65 points
  localparam logic [6:0] QCOS [65] = '{
    7'd96, 7'd96, 7'd96, 7'd96, 7'd96, 7'd95, 7'd95, 7'd95,
    7'd94, 7'd94, 7'd93, 7'd93, 7'd92, 7'd91, 7'd90, 7'd90,
    7'd89, 7'd88, 7'd87, 7'd86, 7'd85, 7'd84, 7'd82, 7'd81,
    7'd80, 7'd78, 7'd77, 7'd76, 7'd74, 7'd73, 7'd71, 7'd70,
    7'd68, 7'd66, 7'd64, 7'd63, 7'd61, 7'd59, 7'd57, 7'd55,
    7'd53, 7'd51, 7'd49, 7'd47, 7'd45, 7'd43, 7'd41, 7'd39,
    7'd37, 7'd35, 7'd32, 7'd30, 7'd28, 7'd26, 7'd23, 7'd21,
    7'd19, 7'd16, 7'd14, 7'd12, 7'd9,  7'd7,  7'd5,  7'd2,
    7'd0
  };

  // raised cosine factor in q0.8, 160 - 96*cos, capped at 255
  function automatic logic [7:0] breath_factor(input logic [7:0] phase);
    logic [8:0] ofs;
    logic [6:0] qi;
    logic [8:0] sum;
    begin
      ofs = '0;
      if (phase <= 8'd64) begin
        qi  = phase[6:0];
        sum = 9'd160 - 9'(QCOS[qi]);
      end else if (phase <= 8'd128) begin
        ofs = 9'd128 - {1'b0, phase};
        qi  = ofs[6:0];
        sum = 9'd160 + 9'(QCOS[qi]);
      end else if (phase <= 8'd192) begin
        ofs = {1'b0, phase} - 9'd128;
        qi  = ofs[6:0];
        sum = 9'd160 + 9'(QCOS[qi]);
      end else begin
        ofs = 9'd256 - {1'b0, phase};
        qi  = ofs[6:0];
        sum = 9'd160 - 9'(QCOS[qi]);
      end
      return (sum > 9'd255) ? 8'd255 : sum[7:0];
    end
  endfunction

endpackage

FILE: hdl/slpg_front.sv
module slpg_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  slpg_pkg::cfg_t                 cfg_i,
  input  logic                           s_valid_i,
  // time_us[47:0], new_mode[50:48], upload_active[51], upload_percent[58:52]
  input  logic [slpg_pkg::S_DATA_W-1:0]  s_data_i,
  // command[1:0]
  input  logic [slpg_pkg::S_USER_W-1:0]  s_user_i,
  output logic                           tick_vld_o,
  output slpg_pkg::tick_t                tick_o
);
  import slpg_pkg::*;

  logic              in_vld_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [TIME_W-1:0] time_q;
  logic [MODE_W-1:0] nm_q;
  logic              up_q;
  logic [PCT_W-1:0]  pct_q;

  mode_e             mode_q, mode_d;
  logic [TIME_W-1:0] tel_q, tel_d;

  logic [CNT_W-1:0]  cnt;
  logic [PCT_W-1:0]  pct_sat;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] elapsed;
  logic              fresh;
  mode_e             show;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en_i) begin
      in_vld_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s_valid_i) begin
      cmd_q  <= s_user_i;
      time_q <= s_data_i[TIME_W-1:0];
      nm_q   <= s_data_i[TIME_W +: MODE_W];
      up_q   <= s_data_i[TIME_W + MODE_W];
      pct_q  <= s_data_i[TIME_W + MODE_W + 1 +: PCT_W];
    end
  end

  // mode and telemetry state updates
  always_comb begin
    mode_d = mode_q;
    tel_d  = tel_q;
    if (en_i && in_vld_q) begin
      if (cmd_q == CMD_MODE && nm_q <= MODE_RUN) begin
        mode_d = mode_e'(nm_q);
      end
      if (cmd_q == CMD_TELEM) begin
        tel_d = time_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF;
      tel_q  <= '0;
    end else begin
      mode_q <= mode_d;
      tel_q  <= tel_d;
    end
  end

  // frame setup for a tick
  always_comb begin
    cnt     = (cfg_i.lamp_count > 4'(MAX_LAMPS)) ? CNT_W'(MAX_LAMPS)
                                                 : CNT_W'(cfg_i.lamp_count);
    pct_sat = (pct_q > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct_q;
    age     = time_q - tel_q;
    fresh   = (tel_q != '0) && (age < TIME_W'(cfg_i.idle_window));
    elapsed = time_q - cfg_i.start_time;
    case (mode_q)
      MODE_WAIT, MODE_RUN: show = fresh ? MODE_RUN : MODE_WAIT;
      default:             show = mode_q;
    endcase
  end

  assign tick_vld_o       = in_vld_q && (cmd_q == CMD_TICK) && (cnt != '0);
  assign tick_o.meta.show = show;
  assign tick_o.meta.up   = up_q;
  assign tick_o.meta.count = cnt;
  assign tick_o.meta.lit  = '0;
  assign tick_o.meta.dim  = cfg_i.dim_level;
  assign tick_o.meta.lsb  = elapsed[LSB_W-1:0];
  assign tick_o.prod      = PROD_W'(cnt) * PROD_W'(pct_sat);
  assign tick_o.x         = elapsed[TIME_W-1:LSB_W];

endmodule

FILE: hdl/slpg_breath.sv
module slpg_breath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             tick_vld_i,
  input  slpg_pkg::tick_t  tick_i,
  output logic             frame_vld_o,
  output slpg_pkg::frame_t frame_o
);
  import slpg_pkg::*;

  localparam int NSTG = 8;

  // stage valids: 0 input, 6 colour stage, 7 frame register
  logic [NSTG-1:0] vld_q;

  tick_t                     t2_q;
  meta_t                     m3_q, m4_q, m5_q, m6_q, m7_q, m8_q;
  logic [RES_W-1:0]          a3_q;
  logic [PB_W-1:0]           pb3_q;
  logic [P_W-1:0]            pc3_q;
  logic [P_W-1:0]            p4_q, p5_q;
  logic [Q_W-1:0]            q5_q;
  logic [RES_W-1:0]          y6_q;
  logic [7:0]                i7_q;
  logic [CHAN_W-1:0]         f8_q;
  frame_t                    fr_q;

  logic [PROD_W+LIT_RCP_W-1:0] lit_prod;
  meta_t                       m3_d;
  logic [P_W+Q_RCP_W-1:0]      q_prod;
  logic [DQ_W-1:0]             qd;
  logic [DQ_W-1:0]             diff;
  logic [V_W-1:0]              v6;
  logic [V_W+I_RCP_W-1:0]      i_prod;
  logic [2*CHAN_W-1:0]         sc_r, sc_g, sc_b;
  frame_t                      fr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], tick_vld_i};
    end
  end

  // lit lamp count, floor(prod / 100)
  always_comb begin
    lit_prod = (PROD_W+LIT_RCP_W)'(t2_q.prod) * (PROD_W+LIT_RCP_W)'(LIT_RCP);
    m3_d     = t2_q.meta;
    m3_d.lit = lit_prod[LIT_SHIFT +: CNT_W];
  end

  // residue reduction and phase index arithmetic
  always_comb begin
    q_prod = (P_W+Q_RCP_W)'(p4_q) * (P_W+Q_RCP_W)'(Q_RCP);
    qd     = DQ_W'(q5_q) * DQ_W'(ODD_DIV);
    diff   = DQ_W'(p5_q) - qd;
    v6     = {y6_q, 8'b0} + V_W'({m6_q.lsb, 1'b0});
    i_prod = (V_W+I_RCP_W)'(v6) * (V_W+I_RCP_W)'(I_RCP);
  end

  // colour of a status frame
  always_comb begin
    sc_r = (2*CHAN_W)'(SAFE_R) * (2*CHAN_W)'(f8_q);
    sc_g = (2*CHAN_W)'(BOOT_G) * (2*CHAN_W)'(f8_q);
    sc_b = (2*CHAN_W)'(BOOT_B) * (2*CHAN_W)'(f8_q);
    fr_d.up     = m8_q.up;
    fr_d.count  = m8_q.count;
    fr_d.lit    = m8_q.lit;
    fr_d.bright = m8_q.up ? FULL_BR : m8_q.dim;
    fr_d.gam    = !m8_q.up;
    fr_d.red    = '0;
    fr_d.green  = '0;
    fr_d.blue   = '0;
    case (m8_q.show)
      MODE_BOOT: begin
        fr_d.green = sc_g[2*CHAN_W-1:CHAN_W];
        fr_d.blue  = sc_b[2*CHAN_W-1:CHAN_W];
      end
      MODE_SAFE: begin
        fr_d.red = sc_r[2*CHAN_W-1:CHAN_W];
      end
      MODE_WAIT: begin
        fr_d.red   = WAIT_R;
        fr_d.green = WAIT_G;
      end
      MODE_RUN: begin
        fr_d.green = RUN_G;
        fr_d.blue  = RUN_B;
      end
      default: begin
        fr_d.red = '0;
      end
    endcase
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q  <= tick_i;
      m3_q  <= m3_d;
      a3_q  <= t2_q.x[RES_W-1:0];
      pb3_q <= PB_W'(t2_q.x[2*RES_W-1:RES_W]) * PB_W'(R14);
      pc3_q <= P_W'(t2_q.x[X_W-1:2*RES_W]) * P_W'(R28);
      m4_q  <= m3_q;
      p4_q  <= P_W'(a3_q) + P_W'(pb3_q) + pc3_q;
      m5_q  <= m4_q;
      p5_q  <= p4_q;
      q5_q  <= q_prod[Q_SHIFT +: Q_W];
      m6_q  <= m5_q;
      y6_q  <= diff[RES_W-1:0];
      m7_q  <= m6_q;
      i7_q  <= i_prod[I_SHIFT +: 8];
      m8_q  <= m7_q;
      f8_q  <= breath_factor(i7_q);
      fr_q  <= fr_d;
    end
  end

  assign frame_vld_o = vld_q[NSTG-1];
  assign frame_o     = fr_q;

endmodule

FILE: hdl/slpg_emit.sv
module slpg_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          frame_vld_i,
  input  slpg_pkg::frame_t              frame_i,
  output logic                          frame_take_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [slpg_pkg::M_DATA_W-1:0] m_data_o,
  output logic                          m_last_o
);
  import slpg_pkg::*;

  frame_t             fr_q, fr_d;
  logic               busy_q, busy_d;
  logic [LAMP_W-1:0]  nxt_q, nxt_d;
  logic               ov_q, ov_d;

  logic [LAMP_W-1:0]  o_idx_q;
  logic [CHAN_W-1:0]  o_r_q, o_g_q, o_b_q, o_br_q;
  logic               o_gam_q, o_last_q;

  logic               slot;
  logic               last_ld;
  logic               take;
  logic [CNT_W-1:0]   nxt_cnt;
  logic               is_lit;
  logic [CHAN_W-1:0]  l_r, l_g, l_b;

  // lamp sequencing
  always_comb begin
    slot    = !ov_q || m_ready_i;
    nxt_cnt = CNT_W'(nxt_q) + CNT_W'(1);
    last_ld = busy_q && (nxt_cnt == fr_q.count);
    take    = !busy_q || (slot && last_ld);

    fr_d   = fr_q;
    busy_d = busy_q;
    nxt_d  = nxt_q;
    ov_d   = slot ? busy_q : ov_q;
    if (slot && busy_q) begin
      nxt_d = nxt_q + LAMP_W'(1);
      if (last_ld) begin
        busy_d = 1'b0;
      end
    end
    if (take && frame_vld_i) begin
      fr_d   = frame_i;
      nxt_d  = '0;
      busy_d = 1'b1;
    end
  end

  // colour of the lamp being loaded
  always_comb begin
    is_lit = CNT_W'(nxt_q) < fr_q.lit;
    if (fr_q.up) begin
      l_r = '0;
      l_g = is_lit ? UP_G : DIM_G;
      l_b = is_lit ? UP_B : DIM_B;
    end else begin
      l_r = fr_q.red;
      l_g = fr_q.green;
      l_b = fr_q.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      nxt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      nxt_q  <= nxt_d;
      ov_q   <= ov_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    fr_q <= fr_d;
    if (slot && busy_q) begin
      o_idx_q  <= nxt_q;
      o_r_q    <= l_r;
      o_g_q    <= l_g;
      o_b_q    <= l_b;
      o_br_q   <= fr_q.bright;
      o_gam_q  <= fr_q.gam;
      o_last_q <= last_ld;
    end
  end

  assign frame_take_o = take;
  assign m_valid_o    = ov_q;
  assign m_last_o     = o_last_q;
  assign m_data_o     = M_DATA_W'({o_gam_q, o_br_q, o_b_q, o_g_q, o_r_q, o_idx_q});

endmodule

FILE: hdl/status_lamp_pattern_generator_core.sv
// Status lamp colour generator.
// Input words arrive on the s_axis channel; tuser holds the command (frame
// tick, set mode, telemetry seen), tdata the time stamp, new mode and upload
// state. Set mode and telemetry words only update internal state and produce
// nothing. A frame tick produces one word per lamp on the m_axis channel,
// lamp 0 first, with tlast on the final lamp.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i: 0 lamp
// count, 1 breathing start time, 2 idle window, 3 dim level. The user must
// write them only while the block is idle; the block does not enforce this.
// A tick passes the input register, the phase pipeline (48 bit time
// reduction modulo the breathing period, then table lookup and channel
// scaling), the sequencer's frame register and the output register. The
// block accepts one input word per cycle while s_axis_tready is high; a
// tick holds the lamp sequencer until its last lamp word is loaded.
// When the receiver stalls, the sequencer holds its word and the pipeline
// freezes once its last stage holds a frame; s_axis_tready then drops.
// Reset clears mode to off, telemetry to never seen, all words in flight and
// the registers to their defaults (8 lamps, start 0, window 2 s, dim 40).
module status_lamp_pattern_generator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [slpg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [slpg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // time_us[47:0], new_mode[50:48], upload_active[51], upload_percent[58:52]
  input  logic [slpg_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // command[1:0]
  input  logic [slpg_pkg::S_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // lamp_index[2:0], red[10:3], green[18:11], blue[26:19],
  // frame_brightness[34:27], gamma_on[35]
  output logic [slpg_pkg::M_DATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);
  import slpg_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   adv;
  logic   tick_vld;
  tick_t  tick;
  logic   frame_vld;
  frame_t frame;
  logic   frame_take;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LAMP_COUNT:  cfg_d.lamp_count  = cfg_data_i[3:0];
        REG_START_TIME:  cfg_d.start_time  = cfg_data_i[TIME_W-1:0];
        REG_IDLE_WINDOW: cfg_d.idle_window = cfg_data_i[IDLE_W-1:0];
        REG_DIM_LEVEL:   cfg_d.dim_level   = cfg_data_i[CHAN_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lamp_count  <= 4'd8;
      cfg_q.start_time  <= '0;
      cfg_q.idle_window <= 22'd2000000;
      cfg_q.dim_level   <= 8'd40;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline moves unless a finished frame waits for the sequencer
  assign adv           = !frame_vld || frame_take;
  assign s_axis_tready = adv;

  slpg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .cfg_i      (cfg_q),
    .s_valid_i  (s_axis_tvalid),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .tick_vld_o (tick_vld),
    .tick_o     (tick)
  );

  slpg_breath u_breath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .tick_vld_i  (tick_vld),
    .tick_i      (tick),
    .frame_vld_o (frame_vld),
    .frame_o     (frame)
  );

  slpg_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_vld_i  (frame_vld),
    .frame_i      (frame),
    .frame_take_o (frame_take),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_last_o     (m_axis_tlast)
  );

endmodule
